// ===== design/tsg_pkg.sv =====
// shared types and constants of the tile shade grid store
`timescale 1ns / 1ps

package tsg_pkg;

   // field widths
   localparam int COORD_W = 9;   // anchor coordinate plus offset, no wrap
   localparam int EXT_W   = 4;
   localparam int LVL_W   = 3;
   localparam int SHADE_W = 8;
   localparam int DIM_W   = 9;   // effective width or height, up to 256
   localparam int LCNT_W  = 4;   // effective level count, up to 8
   localparam int WH_W    = 17;  // width times height, up to 65536
   localparam int LOFF_W  = 20;  // level offset and full linear address sum
   localparam int EXTC_W  = 7;   // compare width for the extent clamp

   // job queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;
   localparam int Q_CNT_W = 2;

   // result buffer in the back part
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // configuration register indexes
   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_GRID_LEVELS = 2'd2;

   typedef enum logic [1:0] {
      REQ_READ   = 2'd0,
      REQ_CORNER = 2'd1,
      REQ_WALL   = 2'd2,
      REQ_RECT   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RUN
   } back_state_type;

   // every request becomes a rectangle of cells
   typedef struct packed {
      logic               is_read;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] z;
      logic [EXT_W-1:0]   ext_x;
      logic [EXT_W-1:0]   ext_z;
      logic [LVL_W-1:0]   level;
      logic [SHADE_W-1:0] shade;
   } job_type;

   typedef struct packed {
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
      logic [LCNT_W-1:0] levels;
   } grid_size_type;

   // control bits that follow one cell down the back pipeline
   typedef struct packed {
      logic valid;
      logic write;
      logic read;
      logic last;
      logic in_grid;
   } tok_type;

endpackage

// ===== design/tsg_front.sv =====
// front part: takes requests and turns each into a rectangle job
`timescale 1ns / 1ps

module tsg_front #(
   parameter int MAX_EXTENT = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [7:0]                    req_x_coord,
   input  logic [7:0]                    req_z_coord,
   input  logic [tsg_pkg::LVL_W-1:0]     req_level_index,
   input  logic [1:0]                    req_wall_orientation,
   input  logic [tsg_pkg::EXT_W-1:0]     req_extent_x,
   input  logic [tsg_pkg::EXT_W-1:0]     req_extent_z,
   input  logic [tsg_pkg::SHADE_W-1:0]   req_shade_value,
   input  logic                          clearing,
   output logic                          job_valid,
   output tsg_pkg::job_type              job,
   input  logic                          job_ready
);

   logic                          fr_valid_ff, fr_valid_in;
   tsg_pkg::job_type              fr_job_ff, fr_job_in;
   tsg_pkg::job_type              decoded;
   logic                          accept;
   logic [tsg_pkg::COORD_W-1:0]   x0, x1, z0, z1;
   logic [tsg_pkg::EXT_W-1:0]     ext_x_c, ext_z_c;

   // anchor and its neighbors, one bit wider so nothing wraps
   assign x0 = {1'b0, req_x_coord};
   assign z0 = {1'b0, req_z_coord};
   assign x1 = x0 + tsg_pkg::COORD_W'(1);
   assign z1 = z0 + tsg_pkg::COORD_W'(1);

   // extent saturation
   assign ext_x_c = ({3'b000, req_extent_x} > tsg_pkg::EXTC_W'(MAX_EXTENT)) ?
                    tsg_pkg::EXT_W'(MAX_EXTENT) : req_extent_x;
   assign ext_z_c = ({3'b000, req_extent_z} > tsg_pkg::EXTC_W'(MAX_EXTENT)) ?
                    tsg_pkg::EXT_W'(MAX_EXTENT) : req_extent_z;

   // request kind and orientation to base cell and extent
   always_comb begin
      decoded.is_read = 1'b0;
      decoded.x       = x0;
      decoded.z       = z0;
      decoded.ext_x   = tsg_pkg::EXT_W'(1);
      decoded.ext_z   = tsg_pkg::EXT_W'(1);
      decoded.level   = req_level_index;
      decoded.shade   = req_shade_value;
      unique case (tsg_pkg::req_kind_type'(req_type))
         tsg_pkg::REQ_READ: begin
            decoded.is_read = 1'b1;
         end
         tsg_pkg::REQ_CORNER: begin
            case (req_wall_orientation)
               2'd0:    decoded.z = z1;
               2'd1: begin
                  decoded.x = x1;
                  decoded.z = z1;
               end
               2'd2:    decoded.x = x1;
               default: ;
            endcase
         end
         tsg_pkg::REQ_WALL: begin
            case (req_wall_orientation)
               2'd0:    decoded.ext_z = tsg_pkg::EXT_W'(2);
               2'd1: begin
                  decoded.z     = z1;
                  decoded.ext_x = tsg_pkg::EXT_W'(2);
               end
               2'd2: begin
                  decoded.x     = x1;
                  decoded.ext_z = tsg_pkg::EXT_W'(2);
               end
               default: decoded.ext_x = tsg_pkg::EXT_W'(2);
            endcase
         end
         tsg_pkg::REQ_RECT: begin
            decoded.ext_x = ext_x_c;
            decoded.ext_z = ext_z_c;
         end
      endcase
   end

   // input handshake, held off while clearing or a held job waits
   assign req_stall = clearing || (fr_valid_ff && !job_ready);
   assign accept    = req_valid && !req_stall;

   // job register toward the queue
   always_comb begin
      fr_valid_in = fr_valid_ff;
      fr_job_in   = fr_job_ff;
      if (accept) begin
         fr_valid_in = 1'b1;
         fr_job_in   = decoded;
      end else if (job_ready) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      fr_job_ff <= fr_job_in;
   end

   assign job_valid = fr_valid_ff;
   assign job       = fr_job_ff;

endmodule

// ===== design/tsg_queue.sv =====
// short job queue between the front and the back part
`timescale 1ns / 1ps

module tsg_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  tsg_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output tsg_pkg::job_type pop_data
);

   tsg_pkg::job_type              slot_ff [tsg_pkg::Q_DEPTH];
   logic [tsg_pkg::Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [tsg_pkg::Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [tsg_pkg::Q_CNT_W-1:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   assign push_ready = count_ff != tsg_pkg::Q_CNT_W'(tsg_pkg::Q_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + tsg_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + tsg_pkg::Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + tsg_pkg::Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - tsg_pkg::Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/tsg_back.sv =====
// back part: walks job cells, computes addresses, owns the shade memory
`timescale 1ns / 1ps

module tsg_back #(
   parameter int DEPTH = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tsg_pkg::grid_size_type        grid,
   input  logic                          job_valid,
   input  tsg_pkg::job_type              job_data,
   output logic                          job_pop,
   output logic                          clearing,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tsg_pkg::SHADE_W-1:0]   rsp_read_shade,
   output logic                          rsp_bad_read
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam int ZW_W = tsg_pkg::COORD_W + tsg_pkg::DIM_W;

   // sequencer
   tsg_pkg::back_state_type        state_ff, state_in;
   logic [ADDR_W-1:0]              clr_addr_ff, clr_addr_in;
   tsg_pkg::job_type               job_ff, job_in;
   logic [tsg_pkg::EXT_W-1:0]      i_ff, i_in, j_ff, j_in;
   logic [tsg_pkg::RSP_CNT_W-1:0]  pend_ff, pend_in;
   logic                           start, issue;

   // current cell
   tsg_pkg::job_type               src;
   logic [tsg_pkg::EXT_W-1:0]      ci, cj;
   logic [tsg_pkg::COORD_W-1:0]    cx, cz;
   logic                           empty, cell_last, in_grid, j_wrap;

   // address pipeline
   logic [2*tsg_pkg::DIM_W-1:0]    wh_full;
   logic [tsg_pkg::WH_W-1:0]       wh_ff;
   tsg_pkg::tok_type               a_tok_ff, a_tok_in;
   logic [tsg_pkg::COORD_W-1:0]    a_x_ff, a_z_ff;
   logic [tsg_pkg::LVL_W-1:0]      a_level_ff;
   logic [tsg_pkg::SHADE_W-1:0]    a_shade_ff;
   logic [ZW_W-1:0]                zw;
   logic [tsg_pkg::LOFF_W-1:0]     loff;
   tsg_pkg::tok_type               b_tok_ff;
   logic [tsg_pkg::COORD_W-1:0]    b_x_ff;
   logic [ZW_W-1:0]                b_zw_ff;
   logic [tsg_pkg::LOFF_W-1:0]     b_loff_ff;
   logic [tsg_pkg::SHADE_W-1:0]    b_shade_ff;
   logic [tsg_pkg::LOFF_W-1:0]     addr_sum;
   tsg_pkg::tok_type               c_tok_ff;
   logic [ADDR_W-1:0]              c_addr_ff;
   logic [tsg_pkg::SHADE_W-1:0]    c_shade_ff;
   tsg_pkg::tok_type               d_tok_ff;

   // shade memory
   logic [tsg_pkg::SHADE_W-1:0]    mem_ff [DEPTH];
   logic [tsg_pkg::SHADE_W-1:0]    mem_q_ff;
   logic [ADDR_W-1:0]              mem_addr;
   logic                           mem_we;
   logic [tsg_pkg::SHADE_W-1:0]    mem_wd;

   // result buffer
   logic [tsg_pkg::SHADE_W-1:0]    rb_shade_ff [tsg_pkg::RSP_DEPTH];
   logic                           rb_bad_ff [tsg_pkg::RSP_DEPTH];
   logic [tsg_pkg::RSP_PTR_W-1:0]  rb_wr_ff, rb_wr_in, rb_rd_ff, rb_rd_in;
   logic [tsg_pkg::RSP_CNT_W-1:0]  rb_count_ff, rb_count_in;
   logic                           rb_push, rb_pop;
   logic [tsg_pkg::SHADE_W-1:0]    rb_shade;
   logic                           rb_bad;

   // cell source: queue head on the first cell, held job afterwards
   always_comb begin
      if (state_ff == tsg_pkg::BK_RUN) begin
         src = job_ff;
         ci  = i_ff;
         cj  = j_ff;
      end else begin
         src = job_data;
         ci  = '0;
         cj  = '0;
      end
   end

   assign empty     = (src.ext_x == '0) || (src.ext_z == '0);
   assign j_wrap    = cj == (src.ext_z - tsg_pkg::EXT_W'(1));
   assign cell_last = empty || (j_wrap && (ci == (src.ext_x - tsg_pkg::EXT_W'(1))));
   assign cx        = src.x + tsg_pkg::COORD_W'(ci);
   assign cz        = src.z + tsg_pkg::COORD_W'(cj);
   assign in_grid   = (cx < grid.width) && (cz < grid.height) &&
                      ({1'b0, src.level} < grid.levels);

   // a new job may start only while a result slot is still free
   assign start = (state_ff == tsg_pkg::BK_IDLE) && job_valid &&
                  (pend_ff < tsg_pkg::RSP_CNT_W'(tsg_pkg::RSP_DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsg_pkg::BK_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = tsg_pkg::BK_IDLE;
            end
         end
         tsg_pkg::BK_IDLE: begin
            if (start && !cell_last) begin
               state_in = tsg_pkg::BK_RUN;
            end
         end
         tsg_pkg::BK_RUN: begin
            if (cell_last) begin
               state_in = tsg_pkg::BK_IDLE;
            end
         end
         default: state_in = tsg_pkg::BK_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      issue    = 1'b0;
      job_pop  = 1'b0;
      clearing = 1'b0;
      unique case (state_ff)
         tsg_pkg::BK_CLEAR: clearing = 1'b1;
         tsg_pkg::BK_IDLE: begin
            issue   = start;
            job_pop = start;
         end
         tsg_pkg::BK_RUN:   issue = 1'b1;
         default: ;
      endcase
   end

   // cell counters, z steps fastest
   always_comb begin
      job_in      = start ? job_data : job_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      clr_addr_in = clr_addr_ff;
      if (issue) begin
         if (j_wrap) begin
            j_in = '0;
            i_in = ci + tsg_pkg::EXT_W'(1);
         end else begin
            j_in = cj + tsg_pkg::EXT_W'(1);
            i_in = ci;
         end
      end
      if (clearing) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end
   end

   // results reserved from job start until their transfer
   always_comb begin
      pend_in = pend_ff;
      if (start && !rb_pop) begin
         pend_in = pend_ff + tsg_pkg::RSP_CNT_W'(1);
      end else if (rb_pop && !start) begin
         pend_in = pend_ff - tsg_pkg::RSP_CNT_W'(1);
      end
   end

   // token for the issued cell
   always_comb begin
      a_tok_in.valid   = issue;
      a_tok_in.write   = issue && !src.is_read && !empty && in_grid;
      a_tok_in.read    = issue && src.is_read;
      a_tok_in.last    = issue && cell_last;
      a_tok_in.in_grid = in_grid;
   end

   // address products and sum
   assign wh_full  = grid.width * grid.height;
   assign zw       = a_z_ff * grid.width;
   assign loff     = a_level_ff * wh_ff;
   assign addr_sum = tsg_pkg::LOFF_W'(b_x_ff) + tsg_pkg::LOFF_W'(b_zw_ff) + b_loff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= tsg_pkg::BK_CLEAR;
         clr_addr_ff <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
         pend_ff     <= '0;
         a_tok_ff    <= '0;
         b_tok_ff    <= '0;
         c_tok_ff    <= '0;
         d_tok_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         pend_ff     <= pend_in;
         a_tok_ff    <= a_tok_in;
         b_tok_ff    <= a_tok_ff;
         c_tok_ff    <= b_tok_ff;
         d_tok_ff    <= c_tok_ff;
      end
      job_ff     <= job_in;
      wh_ff      <= wh_full[tsg_pkg::WH_W-1:0];
      a_x_ff     <= cx;
      a_z_ff     <= cz;
      a_level_ff <= src.level;
      a_shade_ff <= src.shade;
      b_x_ff     <= a_x_ff;
      b_zw_ff    <= zw;
      b_loff_ff  <= loff;
      b_shade_ff <= a_shade_ff;
      c_addr_ff  <= addr_sum[ADDR_W-1:0];
      c_shade_ff <= b_shade_ff;
   end

   // single port memory, clearing pass takes the port after reset
   assign mem_addr = clearing ? clr_addr_ff : c_addr_ff;
   assign mem_we   = clearing || c_tok_ff.write;
   assign mem_wd   = clearing ? '0 : c_shade_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr] <= mem_wd;
      end
      mem_q_ff <= mem_ff[mem_addr];
   end

   // result of the last cell of each job
   assign rb_push  = d_tok_ff.valid && d_tok_ff.last;
   assign rb_shade = (d_tok_ff.read && d_tok_ff.in_grid) ? mem_q_ff : '0;
   assign rb_bad   = d_tok_ff.read && !d_tok_ff.in_grid;

   assign rsp_valid      = rb_count_ff != '0;
   assign rb_pop         = rsp_valid && !rsp_stall;
   assign rsp_read_shade = rb_shade_ff[rb_rd_ff];
   assign rsp_bad_read   = rb_bad_ff[rb_rd_ff];

   // result buffer pointers
   always_comb begin
      rb_wr_in    = rb_wr_ff;
      rb_rd_in    = rb_rd_ff;
      rb_count_in = rb_count_ff;
      if (rb_push) begin
         rb_wr_in = rb_wr_ff + tsg_pkg::RSP_PTR_W'(1);
      end
      if (rb_pop) begin
         rb_rd_in = rb_rd_ff + tsg_pkg::RSP_PTR_W'(1);
      end
      if (rb_push && !rb_pop) begin
         rb_count_in = rb_count_ff + tsg_pkg::RSP_CNT_W'(1);
      end else if (rb_pop && !rb_push) begin
         rb_count_in = rb_count_ff - tsg_pkg::RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rb_wr_ff    <= '0;
         rb_rd_ff    <= '0;
         rb_count_ff <= '0;
      end else begin
         rb_wr_ff    <= rb_wr_in;
         rb_rd_ff    <= rb_rd_in;
         rb_count_ff <= rb_count_in;
      end
      if (rb_push) begin
         rb_shade_ff[rb_wr_ff] <= rb_shade;
         rb_bad_ff[rb_wr_ff]   <= rb_bad;
      end
   end

endmodule

// ===== design/tile_shade_grid_store.sv =====
// top level of the tile shade grid store: size registers and part wiring
`timescale 1ns / 1ps

// Shade grid of MAX_WIDTH x MAX_HEIGHT x MAX_LEVELS 8-bit cells in one
// single-port memory. After reset a clearing pass writes every cell to zero,
// one cell a cycle, MAX_WIDTH*MAX_HEIGHT*MAX_LEVELS cells in all (65536 at
// the defaults); req_stall stays high during it, size writes are taken as
// usual. Every request is turned into a rectangle of cells and the back
// sequencer issues one cell a cycle to the memory port: reads and corner
// writes are one cell, wall writes two, rectangle writes extent_x*extent_z
// cells (one when an extent is zero). One response per request, in request
// order; up to four responses may wait on a stalled response side before
// the back part stops starting jobs. csr_ready is always high; sizes are to
// be changed only while no request is in flight; the block does not
// enforce this.

module tile_shade_grid_store #(
   parameter int MAX_WIDTH  = 128,
   parameter int MAX_HEIGHT = 128,
   parameter int MAX_LEVELS = 4,
   parameter int MAX_EXTENT = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [7:0]                    req_x_coord,
   input  logic [7:0]                    req_z_coord,
   input  logic [tsg_pkg::LVL_W-1:0]     req_level_index,
   input  logic [1:0]                    req_wall_orientation,
   input  logic [tsg_pkg::EXT_W-1:0]     req_extent_x,
   input  logic [tsg_pkg::EXT_W-1:0]     req_extent_z,
   input  logic [tsg_pkg::SHADE_W-1:0]   req_shade_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tsg_pkg::SHADE_W-1:0]   rsp_read_shade,
   output logic                          rsp_bad_read,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_LEVELS;

   logic [7:0]                width_ff, width_in;
   logic [7:0]                height_ff, height_in;
   logic [2:0]                levels_ff, levels_in;
   tsg_pkg::grid_size_type    grid;
   logic                      clearing;
   logic                      fr_job_valid, q_push_ready;
   tsg_pkg::job_type          fr_job;
   logic                      q_pop_valid, q_pop;
   tsg_pkg::job_type          q_job;

   assign csr_ready = 1'b1;

   // size register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      levels_in = levels_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tsg_pkg::CSR_GRID_WIDTH:  width_in  = csr_data;
            tsg_pkg::CSR_GRID_HEIGHT: height_in = csr_data;
            tsg_pkg::CSR_GRID_LEVELS: levels_in = csr_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd128;
         height_ff <= 8'd128;
         levels_ff <= 3'd4;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         levels_ff <= levels_in;
      end
   end

   // sizes saturated at the store dimensions
   always_comb begin
      grid.width  = ({1'b0, width_ff} > tsg_pkg::DIM_W'(MAX_WIDTH)) ?
                    tsg_pkg::DIM_W'(MAX_WIDTH) : {1'b0, width_ff};
      grid.height = ({1'b0, height_ff} > tsg_pkg::DIM_W'(MAX_HEIGHT)) ?
                    tsg_pkg::DIM_W'(MAX_HEIGHT) : {1'b0, height_ff};
      grid.levels = ({1'b0, levels_ff} > tsg_pkg::LCNT_W'(MAX_LEVELS)) ?
                    tsg_pkg::LCNT_W'(MAX_LEVELS) : {1'b0, levels_ff};
   end

   tsg_front #(
      .MAX_EXTENT (MAX_EXTENT)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_type             (req_type),
      .req_x_coord          (req_x_coord),
      .req_z_coord          (req_z_coord),
      .req_level_index      (req_level_index),
      .req_wall_orientation (req_wall_orientation),
      .req_extent_x         (req_extent_x),
      .req_extent_z         (req_extent_z),
      .req_shade_value      (req_shade_value),
      .clearing             (clearing),
      .job_valid            (fr_job_valid),
      .job                  (fr_job),
      .job_ready            (q_push_ready)
   );

   tsg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fr_job_valid),
      .push_ready (q_push_ready),
      .push_data  (fr_job),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop),
      .pop_data   (q_job)
   );

   tsg_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .grid           (grid),
      .job_valid      (q_pop_valid),
      .job_data       (q_job),
      .job_pop        (q_pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_shade (rsp_read_shade),
      .rsp_bad_read   (rsp_bad_read)
   );

endmodule
